### src/dssm_pkg.sv
// ----------------------------------------------------------------------------
// Dive safety stop monitor package
// Shared types, register indexes and reset values for the monitor.
// ----------------------------------------------------------------------------
package dssm_pkg;

  // Field widths
  localparam int unsigned DEPTH_W  = 12;
  localparam int unsigned NST_W    = 10;
  localparam int unsigned STOP_W   = 10;
  localparam int unsigned HOUR_W   = 8;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DURATION      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_DEPTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DEEP_BOUND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_SHALLOW_BOUND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ASCENT_LIMIT       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NO_STOP_LIMIT      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_DEPTH        = 3'd6;

  // Register reset values
  localparam logic [STOP_W-1:0]  RST_STOP_DURATION      = 10'd180;
  localparam logic [DEPTH_W-1:0] RST_REQUIRE_DEPTH      = 12'd300;
  localparam logic [DEPTH_W-1:0] RST_STOP_DEEP_BOUND    = 12'd200;
  localparam logic [DEPTH_W-1:0] RST_STOP_SHALLOW_BOUND = 12'd150;
  localparam logic [DEPTH_W-1:0] RST_ASCENT_LIMIT       = 12'd10;
  localparam logic [NST_W-1:0]   RST_NO_STOP_LIMIT      = 10'd90;
  localparam logic [DEPTH_W-1:0] RST_START_DEPTH        = 12'd40;

  // Clock limits
  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_MAX  = 8'd255;

  typedef struct packed {
    logic               kind;
    logic [DEPTH_W-1:0] depth;
    logic [NST_W-1:0]   no_stop_time;
    logic               wet;
  } item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] max_depth;
    logic               diving;
    logic               stop_active;
    logic [STOP_W-1:0]  stop_left;
    logic               ascent_alarm;
    logic               no_stop_alarm;
    logic               buzzer;
    logic               led;
    logic [HOUR_W-1:0]  clock_hours;
    logic [MIN_W-1:0]   clock_minutes;
    logic [SEC_W-1:0]   clock_seconds;
  } result_t;

  typedef struct packed {
    logic [STOP_W-1:0]  stop_duration;
    logic [DEPTH_W-1:0] require_depth;
    logic [DEPTH_W-1:0] stop_deep_bound;
    logic [DEPTH_W-1:0] stop_shallow_bound;
    logic [DEPTH_W-1:0] ascent_limit;
    logic [NST_W-1:0]   no_stop_limit;
    logic [DEPTH_W-1:0] start_depth;
  } cfg_t;

endpackage

### src/dssm_cfg_regs.sv
// ----------------------------------------------------------------------------
// Dive safety stop monitor configuration registers
// Holds the seven thresholds, written one per transaction on the config port.
// ----------------------------------------------------------------------------
module dssm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dssm_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [dssm_pkg::CFG_DATA_W-1:0] wr_data,
  output dssm_pkg::cfg_t                 cfg
);
  import dssm_pkg::*;

  // Register file; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stop_duration      <= RST_STOP_DURATION;
      cfg.require_depth      <= RST_REQUIRE_DEPTH;
      cfg.stop_deep_bound    <= RST_STOP_DEEP_BOUND;
      cfg.stop_shallow_bound <= RST_STOP_SHALLOW_BOUND;
      cfg.ascent_limit       <= RST_ASCENT_LIMIT;
      cfg.no_stop_limit      <= RST_NO_STOP_LIMIT;
      cfg.start_depth        <= RST_START_DEPTH;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STOP_DURATION:      cfg.stop_duration      <= wr_data[STOP_W-1:0];
        REG_REQUIRE_DEPTH:      cfg.require_depth      <= wr_data[DEPTH_W-1:0];
        REG_STOP_DEEP_BOUND:    cfg.stop_deep_bound    <= wr_data[DEPTH_W-1:0];
        REG_STOP_SHALLOW_BOUND: cfg.stop_shallow_bound <= wr_data[DEPTH_W-1:0];
        REG_ASCENT_LIMIT:       cfg.ascent_limit       <= wr_data[DEPTH_W-1:0];
        REG_NO_STOP_LIMIT:      cfg.no_stop_limit      <= wr_data[NST_W-1:0];
        REG_START_DEPTH:        cfg.start_depth        <= wr_data[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### src/dssm_tracker.sv
// ----------------------------------------------------------------------------
// Dive safety stop monitor tracker
// Dive state registers and the single-pass update for one sample or tick.
// ----------------------------------------------------------------------------
module dssm_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              update,
  input  dssm_pkg::item_t   item,
  input  dssm_pkg::cfg_t    cfg,
  output dssm_pkg::result_t result
);
  import dssm_pkg::*;

  typedef struct packed {
    logic               was_wet;
    logic               dive_started;
    logic               stop_required;
    logic               stop_running;
    logic [STOP_W-1:0]  stop_remaining;
    logic [DEPTH_W-1:0] last_depth;
    logic [DEPTH_W-1:0] current_depth;
    logic [DEPTH_W-1:0] deepest;
    logic               rise_alarm;
    logic               nostop_alarm;
    logic [HOUR_W-1:0]  hour_count;
    logic [MIN_W-1:0]   minute_count;
    logic [SEC_W-1:0]   second_count;
  } dive_state_t;

  dive_state_t dive;
  dive_state_t dive_next;

  // Next state for the item in hand.
  always_comb begin
    logic [DEPTH_W-1:0] d;
    logic               in_band;
    d = item.depth;
    dive_next = dive;
    in_band = 1'b0;
    if (item.kind == KIND_SAMPLE) begin
      dive_next.current_depth = d;
      dive_next.last_depth    = d;
      if (dive.dive_started || d >= cfg.start_depth) begin
        // First qualifying sample starts the dive and clears the clock.
        if (!dive.dive_started) begin
          dive_next.dive_started = 1'b1;
          dive_next.hour_count   = '0;
          dive_next.minute_count = '0;
          dive_next.second_count = '0;
          dive_next.deepest      = d;
        end else if (d > dive.deepest) begin
          dive_next.deepest = d;
        end
        // Arm the stop when deep, start it on rising to the deep bound.
        dive_next.stop_required = dive.stop_required || (d > cfg.require_depth);
        if (dive_next.stop_required && d <= cfg.stop_deep_bound) begin
          dive_next.stop_required  = 1'b0;
          dive_next.stop_running   = 1'b1;
          dive_next.stop_remaining = cfg.stop_duration;
        end
        dive_next.rise_alarm = (dive.last_depth > d) &&
                               ((dive.last_depth - d) > cfg.ascent_limit);
        dive_next.nostop_alarm = (item.no_stop_time <= cfg.no_stop_limit);
      end
    end else begin
      // Wet edge clears the whole dive; a dry tick drops the wet flag.
      if (item.wet) begin
        if (!dive.was_wet) begin
          dive_next = '0;
          dive_next.was_wet = 1'b1;
        end
      end else begin
        dive_next.was_wet = 1'b0;
      end
      // Stop countdown, only while inside the stop band.
      if (dive_next.stop_running) begin
        in_band = (dive_next.current_depth <= cfg.stop_deep_bound) &&
                  (dive_next.current_depth >= cfg.stop_shallow_bound);
        if (in_band && dive_next.stop_remaining != '0) begin
          dive_next.stop_remaining = dive_next.stop_remaining - 1'b1;
        end
        if (dive_next.stop_remaining == '0) begin
          dive_next.stop_running = 1'b0;
        end
      end
      // Dive clock; hours saturate.
      if (dive_next.was_wet) begin
        if (dive_next.second_count >= SEC_LAST) begin
          dive_next.second_count = '0;
          if (dive_next.minute_count >= MIN_LAST) begin
            dive_next.minute_count = '0;
            if (dive_next.hour_count != HOUR_MAX) begin
              dive_next.hour_count = dive_next.hour_count + 1'b1;
            end
          end else begin
            dive_next.minute_count = dive_next.minute_count + 1'b1;
          end
        end else begin
          dive_next.second_count = dive_next.second_count + 1'b1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dive <= '0;
    end else if (update) begin
      dive <= dive_next;
    end
  end

  // Result is taken from the state after the update.
  always_comb begin
    result.max_depth     = dive_next.deepest;
    result.diving        = dive_next.dive_started;
    result.stop_active   = dive_next.stop_running;
    result.stop_left     = dive_next.stop_remaining;
    result.ascent_alarm  = dive_next.rise_alarm;
    result.no_stop_alarm = dive_next.nostop_alarm;
    result.buzzer        = dive_next.rise_alarm | dive_next.nostop_alarm;
    result.led           = dive_next.nostop_alarm;
    result.clock_hours   = dive_next.hour_count;
    result.clock_minutes = dive_next.minute_count;
    result.clock_seconds = dive_next.second_count;
  end

endmodule

### src/dive_safety_stop_monitor_core.sv
// Each item passes through the input register and then the result register;
// it waits in the input register while the result register is stalled.
// Throughput: one item per cycle while out_ready is high; the input and result
// registers form a two-stage pipeline and the dive state updates in a single pass.
// Reset clears the pipeline and all dive state and loads the threshold
// registers with their default values.
// ----------------------------------------------------------------------------
// Dive safety stop monitor core
// Tracks a dive from depth samples and one-second ticks, raising alarms.
// ----------------------------------------------------------------------------
module dive_safety_stop_monitor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dssm_pkg::item_t                 in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dssm_pkg::result_t               out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dssm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dssm_pkg::*;

  logic    hold_valid;
  item_t   hold_item;
  logic    advance;
  cfg_t    cfg;
  result_t result;

  // The held item moves on whenever the result register is free or draining.
  assign advance   = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;
  assign cfg_ready = 1'b1;

  dssm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dssm_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .update (advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

### sim/dive_safety_stop_monitor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dive safety stop monitor testbench
// Drives depth samples and one-second ticks through the valid/ready channels,
// keeps a cycle-free model of the dive state and compares every result,
// field by field, with the expectation for its item. Register settings are
// changed between phases, extremes and an inverted stop band among them, and
// a wet stretch of ticks rolls the dive clock over minute boundaries.
// ----------------------------------------------------------------------------
module dive_safety_stop_monitor_core_tb;
  import dssm_pkg::*;

  localparam int LATENCY        = 2;
  localparam int DRAIN_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 880;
  localparam int RANDOM_PHASES  = 8;
  localparam int MAX_REPORTS    = 40;
  localparam int CLOCK_TICKS    = 125;
  localparam int DEPTH_MAX      = (1 << DEPTH_W) - 1;
  localparam int NST_MAX        = (1 << NST_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  item_t                 in_item;
  logic                  out_valid;
  logic                  out_ready;
  result_t               out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Expected dive state, kept in step with accepted transactions.
  cfg_t               model_cfg;
  logic               wet_seen;
  logic               in_dive;
  logic               stop_armed;
  logic               stop_counting;
  logic [STOP_W-1:0]  stop_ticks;
  logic [DEPTH_W-1:0] prev_depth;
  logic [DEPTH_W-1:0] depth_now;
  logic [DEPTH_W-1:0] deepest_depth;
  logic               rise_flag;
  logic               nostop_flag;
  logic [HOUR_W-1:0]  hours;
  logic [MIN_W-1:0]   minutes;
  logic [SEC_W-1:0]   seconds;

  result_t dive_results_q[$];
  result_t want;

  logic steady;
  int   dive_pos;
  int   items_sent;
  int   phase_end;
  int   n_samples;
  int   n_ticks;
  int   n_writes;
  int   n_checked;
  int   n_rises;
  int   n_stops;
  int   n_errors;

  dive_safety_stop_monitor_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Run time limit reached with %0d results outstanding", dive_results_q.size());
    $display("status: fail");
    $finish;
  end

  // Result side back-pressure: stalls about 7 percent of the time unless steady.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 7);
  end

  function automatic cfg_t default_settings();
    cfg_t c;
    c.stop_duration      = RST_STOP_DURATION;
    c.require_depth      = RST_REQUIRE_DEPTH;
    c.stop_deep_bound    = RST_STOP_DEEP_BOUND;
    c.stop_shallow_bound = RST_STOP_SHALLOW_BOUND;
    c.ascent_limit       = RST_ASCENT_LIMIT;
    c.no_stop_limit      = RST_NO_STOP_LIMIT;
    c.start_depth        = RST_START_DEPTH;
    return c;
  endfunction

  // Mostly sensible settings, with the odd inverted band or wide limit.
  function automatic cfg_t random_settings();
    cfg_t c;
    int   deep;
    c.stop_duration = ($urandom_range(0, 9) == 0) ? STOP_W'($urandom_range(0, NST_MAX))
                                                  : STOP_W'($urandom_range(0, 30));
    c.start_depth   = DEPTH_W'($urandom_range(0, 150));
    c.require_depth = DEPTH_W'($urandom_range(150, 1500));
    deep = $urandom_range(60, c.require_depth);
    c.stop_deep_bound = DEPTH_W'(deep);
    if ($urandom_range(0, 5) == 0) begin
      c.stop_shallow_bound = DEPTH_W'(deep + int'($urandom_range(1, 100)));
    end else begin
      c.stop_shallow_bound = DEPTH_W'($urandom_range(0, deep));
    end
    c.ascent_limit  = ($urandom_range(0, 3) == 0) ? DEPTH_W'($urandom_range(0, DEPTH_MAX))
                                                  : DEPTH_W'($urandom_range(5, 60));
    c.no_stop_limit = NST_W'($urandom_range(0, NST_MAX));
    return c;
  endfunction

  // No-stop time near the alarm threshold half of the time.
  function automatic int pick_nst();
    int v;
    if ($urandom_range(0, 1)) begin
      v = int'(model_cfg.no_stop_limit) + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > NST_MAX) v = NST_MAX;
    end else begin
      v = $urandom_range(0, NST_MAX);
    end
    return v;
  endfunction

  // Clears everything that belongs to one dive, including the dive clock.
  task automatic clear_dive_track();
    in_dive       = 1'b0;
    stop_armed    = 1'b0;
    stop_counting = 1'b0;
    stop_ticks    = '0;
    prev_depth    = '0;
    depth_now     = '0;
    deepest_depth = '0;
    rise_flag     = 1'b0;
    nostop_flag   = 1'b0;
    hours         = '0;
    minutes       = '0;
    seconds       = '0;
  endtask

  // Applies one accepted item to the expected state and queues its result.
  task automatic track_dive(input item_t it);
    result_t r;
    if (it.kind == KIND_SAMPLE) begin
      n_samples++;
      depth_now = it.depth;
      if (!in_dive && it.depth < model_cfg.start_depth) begin
        prev_depth = it.depth;
      end else begin
        if (!in_dive) begin
          in_dive       = 1'b1;
          hours         = '0;
          minutes       = '0;
          seconds       = '0;
          deepest_depth = it.depth;
        end
        if (it.depth > deepest_depth) deepest_depth = it.depth;
        if (it.depth > model_cfg.require_depth) stop_armed = 1'b1;
        if (stop_armed && it.depth <= model_cfg.stop_deep_bound) begin
          stop_armed    = 1'b0;
          stop_counting = 1'b1;
          stop_ticks    = model_cfg.stop_duration;
          n_stops++;
        end
        rise_flag = (prev_depth > it.depth) &&
                    ((prev_depth - it.depth) > model_cfg.ascent_limit);
        if (rise_flag) n_rises++;
        nostop_flag = (it.no_stop_time <= model_cfg.no_stop_limit);
        prev_depth  = it.depth;
      end
    end else begin
      n_ticks++;
      // A dry-to-wet change starts a fresh dive record.
      if (it.wet) begin
        if (!wet_seen) begin
          clear_dive_track();
          wet_seen = 1'b1;
        end
      end else begin
        wet_seen = 1'b0;
      end
      // The countdown only moves while the diver is inside the stop band.
      if (stop_counting) begin
        if (depth_now <= model_cfg.stop_deep_bound &&
            depth_now >= model_cfg.stop_shallow_bound && stop_ticks != 0) begin
          stop_ticks = stop_ticks - 1'b1;
        end
        if (stop_ticks == 0) stop_counting = 1'b0;
      end
      // Dive clock, with hours held at their maximum.
      if (wet_seen) begin
        if (seconds == SEC_LAST) begin
          seconds = '0;
          if (minutes == MIN_LAST) begin
            minutes = '0;
            if (hours != HOUR_MAX) hours = hours + 1'b1;
          end else begin
            minutes = minutes + 1'b1;
          end
        end else begin
          seconds = seconds + 1'b1;
        end
      end
    end
    r.max_depth     = deepest_depth;
    r.diving        = in_dive;
    r.stop_active   = stop_counting;
    r.stop_left     = stop_ticks;
    r.ascent_alarm  = rise_flag;
    r.no_stop_alarm = nostop_flag;
    r.buzzer        = rise_flag | nostop_flag;
    r.led           = nostop_flag;
    r.clock_hours   = hours;
    r.clock_minutes = minutes;
    r.clock_seconds = seconds;
    dive_results_q.push_back(r);
    items_sent++;
  endtask

  // Sends one item; valid stays high from one transaction to the next
  // unless a random gap is taken.
  task automatic send_item(input item_t it);
    while (!steady && $urandom_range(0, 99) < 7) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    track_dive(it);
  endtask

  // Fields that a sample ignores are filled at random.
  task automatic send_sample(input int d, input int nst);
    item_t it;
    it.kind         = KIND_SAMPLE;
    it.depth        = d[DEPTH_W-1:0];
    it.no_stop_time = nst[NST_W-1:0];
    it.wet          = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic send_tick(input logic w);
    item_t it;
    it.kind         = KIND_TICK;
    it.depth        = DEPTH_W'($urandom_range(0, DEPTH_MAX));
    it.no_stop_time = NST_W'($urandom_range(0, NST_MAX));
    it.wet          = w;
    send_item(it);
  endtask

  task automatic send_noise();
    item_t it;
    it.kind         = 1'($urandom_range(0, 1));
    it.depth        = DEPTH_W'($urandom_range(0, DEPTH_MAX));
    it.no_stop_time = NST_W'($urandom_range(0, NST_MAX));
    it.wet          = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // Stops sending and waits until every expected result has been checked.
  task automatic wait_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (dive_results_q.size() != 0) begin
      @(posedge clk);
      waited++;
      if (waited > DRAIN_LIMIT) begin
        $display("%0t: %0d results never arrived", $time, dive_results_q.size());
        $display("status: fail");
        $finish;
      end
    end
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STOP_DURATION:      model_cfg.stop_duration      = data[STOP_W-1:0];
      REG_REQUIRE_DEPTH:      model_cfg.require_depth      = data[DEPTH_W-1:0];
      REG_STOP_DEEP_BOUND:    model_cfg.stop_deep_bound    = data[DEPTH_W-1:0];
      REG_STOP_SHALLOW_BOUND: model_cfg.stop_shallow_bound = data[DEPTH_W-1:0];
      REG_ASCENT_LIMIT:       model_cfg.ascent_limit       = data[DEPTH_W-1:0];
      REG_NO_STOP_LIMIT:      model_cfg.no_stop_limit      = data[NST_W-1:0];
      REG_START_DEPTH:        model_cfg.start_depth        = data[DEPTH_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Writes the whole register set once the block has gone quiet.
  task automatic program_cfg(input cfg_t c);
    wait_drained();
    write_reg(REG_STOP_DURATION, CFG_DATA_W'(c.stop_duration));
    write_reg(REG_REQUIRE_DEPTH, c.require_depth);
    write_reg(REG_STOP_DEEP_BOUND, c.stop_deep_bound);
    write_reg(REG_STOP_SHALLOW_BOUND, c.stop_shallow_bound);
    write_reg(REG_ASCENT_LIMIT, c.ascent_limit);
    write_reg(REG_NO_STOP_LIMIT, CFG_DATA_W'(c.no_stop_limit));
    write_reg(REG_START_DEPTH, c.start_depth);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Moves the diver towards a target in random steps, with ticks between
  // samples and the odd stray item, until the phase budget runs out.
  task automatic walk_to(input int target, input int max_step);
    int step;
    while (dive_pos != target && items_sent < phase_end) begin
      step = $urandom_range(1, max_step);
      if (dive_pos < target) begin
        dive_pos = (dive_pos + step > target) ? target : dive_pos + step;
      end else begin
        dive_pos = (dive_pos - step < target) ? target : dive_pos - step;
      end
      if ($urandom_range(0, 99) < 6) begin
        send_noise();
      end else begin
        send_sample(dive_pos, pick_nst());
      end
      if ($urandom_range(0, 1)) send_tick(1'b1);
    end
  endtask

  // One well-formed dive: get wet, descend past the arming depth, rise to
  // the stop band, wait there for a while and surface.
  task automatic run_dive();
    int bottom;
    int asc_step;
    int dwell;
    int lo;
    int hi;
    if ($urandom_range(0, 1)) send_tick(1'b0);
    send_tick(1'b1);
    dive_pos = 0;
    bottom = int'(model_cfg.require_depth) + int'($urandom_range(1, 200));
    if (bottom > DEPTH_MAX) bottom = DEPTH_MAX;
    asc_step = int'(model_cfg.ascent_limit) + 3;
    if (asc_step < 8) asc_step = 8;
    if (asc_step > 400) asc_step = 400;
    lo = int'(model_cfg.stop_shallow_bound);
    hi = int'(model_cfg.stop_deep_bound);
    walk_to(bottom, 120);
    walk_to(hi, asc_step);
    if (lo <= hi) walk_to($urandom_range(lo, hi), asc_step);
    dwell = $urandom_range(2, 40);
    repeat (dwell) begin
      if (items_sent < phase_end) begin
        if (lo <= hi && $urandom_range(0, 4) == 0) begin
          dive_pos = $urandom_range(lo, hi);
          send_sample(dive_pos, pick_nst());
        end else begin
          send_tick(1'b1);
        end
      end
    end
    walk_to(0, asc_step);
    if ($urandom_range(0, 2) == 0) send_tick(1'b0);
  endtask

  // Field extremes, both alarms, the stop cycle and re-wetting at defaults.
  task automatic test_directed_sweep();
    send_tick(1'b0);
    send_tick(1'b1);
    send_sample(0, NST_MAX);
    send_sample(39, 0);
    send_sample(40, 500);
    send_sample(DEPTH_MAX, 0);
    send_sample(DEPTH_MAX, 90);
    send_sample(200, 91);
    send_tick(1'b1);
    send_sample(190, 100);
    send_sample(150, 89);
    send_tick(1'b1);
    send_sample(149, NST_MAX);
    send_tick(1'b1);
    send_sample(301, NST_MAX);
    send_sample(DEPTH_MAX, 512);
    send_sample(201, 512);
    send_sample(200, 512);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // A stop loaded with zero ends on the next tick; an inverted band
  // freezes the countdown.
  task automatic test_special_settings();
    cfg_t c;
    c = default_settings();
    c.stop_duration = '0;
    program_cfg(c);
    send_tick(1'b0);
    send_tick(1'b1);
    send_sample(400, 200);
    send_sample(200, 200);
    send_tick(1'b1);
    send_tick(1'b1);
    c.stop_duration      = 10'd5;
    c.stop_shallow_bound = 12'd300;
    program_cfg(c);
    send_sample(400, 200);
    send_sample(395, 200);
    send_sample(200, 200);
    send_tick(1'b1);
    send_tick(1'b1);
    send_sample(250, 200);
    send_tick(1'b1);
  endtask

  // The sender holds off mid-dive until every result is back.
  task automatic test_pause_mid_dive();
    program_cfg(default_settings());
    phase_end = items_sent + 200;
    send_tick(1'b0);
    send_tick(1'b1);
    dive_pos = 0;
    walk_to(350, 60);
    wait_drained();
    walk_to(180, 8);
    repeat (6) send_tick(1'b1);
    wait_drained();
    walk_to(0, 12);
  endtask

  // Random dives under a series of settings, the defaults and the extremes first.
  task automatic test_random_dives();
    cfg_t c;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: c = default_settings();
        1: c = '0;
        2: c = '1;
        3: begin
          c = random_settings();
          c.stop_shallow_bound = c.stop_deep_bound + 12'd40;
        end
        default: c = random_settings();
      endcase
      program_cfg(c);
      steady = (p == 5);
      phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          run_dive();
        end
      end
    end
    steady = 1'b0;
  endtask

  // A wet stretch with no stalls carries the seconds into the minutes
  // more than once.
  task automatic test_clock_rollover();
    program_cfg(default_settings());
    steady = 1'b1;
    send_tick(1'b0);
    send_tick(1'b1);
    repeat (CLOCK_TICKS) send_tick(1'b1);
    steady = 1'b0;
  endtask

  task automatic report_field(input string fname, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      end
    end
  endtask

  // Each result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (dive_results_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end
      end else begin
        want = dive_results_q.pop_front();
        report_field("max_depth", 32'(want.max_depth), 32'(out_item.max_depth));
        report_field("diving", 32'(want.diving), 32'(out_item.diving));
        report_field("stop_active", 32'(want.stop_active), 32'(out_item.stop_active));
        report_field("stop_left", 32'(want.stop_left), 32'(out_item.stop_left));
        report_field("ascent_alarm", 32'(want.ascent_alarm), 32'(out_item.ascent_alarm));
        report_field("no_stop_alarm", 32'(want.no_stop_alarm),
                     32'(out_item.no_stop_alarm));
        report_field("buzzer", 32'(want.buzzer), 32'(out_item.buzzer));
        report_field("led", 32'(want.led), 32'(out_item.led));
        report_field("clock_hours", 32'(want.clock_hours), 32'(out_item.clock_hours));
        report_field("clock_minutes", 32'(want.clock_minutes),
                     32'(out_item.clock_minutes));
        report_field("clock_seconds", 32'(want.clock_seconds),
                     32'(out_item.clock_seconds));
        n_checked++;
      end
    end
  end

  // Main sequence.
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_STOP_DURATION;
    cfg_data   = '0;
    steady     = 1'b0;
    dive_pos   = 0;
    items_sent = 0;
    phase_end  = 0;
    n_samples  = 0;
    n_ticks    = 0;
    n_writes   = 0;
    n_checked  = 0;
    n_rises    = 0;
    n_stops    = 0;
    n_errors   = 0;
    model_cfg  = default_settings();
    wet_seen   = 1'b0;
    clear_dive_track();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_sweep();
    test_special_settings();
    test_pause_mid_dive();
    test_random_dives();
    test_clock_rollover();
    wait_drained();

    $display("Checked %0d results from %0d samples and %0d ticks, %0d register writes.",
             n_checked, n_samples, n_ticks, n_writes);
    $display("Saw %0d ascent alarms and %0d safety stops; dive clock ended at %0d min %0d s.",
             n_rises, n_stops, minutes, seconds);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
